// ===== src/biquad_cascade_equalizer_core_assert.svh =====
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef BIQUAD_CASCADE_EQUALIZER_CORE_ASSERT_SVH
`define BIQUAD_CASCADE_EQUALIZER_CORE_ASSERT_SVH

// condition that holds at every clock edge
`define BQEQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence that follows in the cycle after the antecedent
`define BQEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bqeq_pkg.sv =====
package bqeq_pkg;

  localparam int STAGE_COUNT    = 5;
  localparam int COEF_FRAC_BITS = 28;
  localparam int NUM_SLOTS      = 5;
  localparam int SAMPLE_W       = 32;
  localparam int COEF_W         = 32;
  localparam int STAGE_FIELD_W  = 3;
  localparam int SLOT_W         = 3;
  localparam int HIST_W         = 48;
  localparam int HALF_W         = HIST_W / 2;
  localparam int MUL_B_W        = SAMPLE_W + 1;
  localparam int PROD_W         = COEF_W + MUL_B_W;
  localparam int ACC_W          = 84;
  localparam int SCALED_W       = ACC_W - COEF_FRAC_BITS;
  localparam int STAGE_W        = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int MAC_STEPS      = 7;
  localparam int STEP_W         = $clog2(MAC_STEPS);

  typedef enum logic {
    CMD_FILTER = 1'b0,
    CMD_COEF   = 1'b1
  } cmd_e;

  typedef enum logic [SLOT_W-1:0] {
    SLOT_B0 = 3'd0,
    SLOT_B1 = 3'd1,
    SLOT_B2 = 3'd2,
    SLOT_A1 = 3'd3,
    SLOT_A2 = 3'd4
  } slot_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SCALE,
    ST_SAT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               coef_wr;
    logic               load;
    logic               mac;
    logic [STEP_W-1:0]  step;
    logic [STAGE_W-1:0] stage;
    logic               scale;
    logic               sat;
    logic               out_load;
  } dp_cmd_t;

  typedef struct packed {
    slot_e slot;
    logic  high;
    logic  sub;
  } step_info_t;

  // mac step order: b0*x, b1*x1, b2*x2, then a1*y1 and a2*y2 as low and high halves
  function automatic step_info_t step_info(input logic [STEP_W-1:0] step);
    step_info_t r;
    unique case (step)
      3'd0:    r = '{slot: SLOT_B0, high: 1'b0, sub: 1'b0};
      3'd1:    r = '{slot: SLOT_B1, high: 1'b0, sub: 1'b0};
      3'd2:    r = '{slot: SLOT_B2, high: 1'b0, sub: 1'b0};
      3'd3:    r = '{slot: SLOT_A1, high: 1'b0, sub: 1'b1};
      3'd4:    r = '{slot: SLOT_A1, high: 1'b1, sub: 1'b1};
      3'd5:    r = '{slot: SLOT_A2, high: 1'b0, sub: 1'b1};
      default: r = '{slot: SLOT_A2, high: 1'b1, sub: 1'b1};
    endcase
    return r;
  endfunction

  function automatic logic [HIST_W-1:0] sat_hist(input logic [SCALED_W-1:0] v);
    logic fits;
    fits = (&v[SCALED_W-1:HIST_W-1]) || !(|v[SCALED_W-1:HIST_W-1]);
    if (fits) return v[HIST_W-1:0];
    return v[SCALED_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [HIST_W-1:0] v);
    logic fits;
    fits = (&v[HIST_W-1:SAMPLE_W-1]) || !(|v[HIST_W-1:SAMPLE_W-1]);
    if (fits) return v[SAMPLE_W-1:0];
    return v[HIST_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage

// ===== src/bqeq_in_if.sv =====
interface bqeq_in_if
  import bqeq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [STAGE_FIELD_W-1:0]   coef_stage;
  logic [SLOT_W-1:0]          coef_slot;
  logic signed [COEF_W-1:0]   coef_value;

  modport source (output valid, command, sample_in, coef_stage, coef_slot, coef_value,
                  input ready);
  modport sink (input valid, command, sample_in, coef_stage, coef_slot, coef_value,
                output ready);
endinterface

// ===== src/bqeq_out_if.sv =====
interface bqeq_out_if
  import bqeq_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

// ===== src/biquad_cascade_equalizer_core.sv =====
// Five-stage direct-form-1 biquad cascade for signed 32-bit samples. A word with command 0
// filters sample_in and returns one sample_out; a word with command 1 writes one Q3.28
// coefficient (stage 0..4, slot b0 b1 b2 a1 a2) and returns nothing, and stage or slot
// numbers out of range are dropped. After reset every stage passes its input through and
// all history is zero. One 32x33 multiplier does all products: each stage takes seven
// multiply steps (the 48-bit output history is multiplied in two halves), one drain step,
// one scaling step and one saturation step. A sample reaches the result register once
// every stage has run, and the next word can be accepted when the core is back in idle;
// a result not yet taken holds the core in its last step until the result register is
// free. A coefficient write leaves the core idle. Input is accepted only while the core
// is idle, and a finished result waits in its own register while the next word is taken.
module biquad_cascade_equalizer_core
  import bqeq_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  bqeq_in_if.sink     in_i,
  bqeq_out_if.source  out_o
);

  dp_cmd_t cmd;

  bqeq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd)
  );

  bqeq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_in_i  (in_i.sample_in),
    .coef_stage_i (in_i.coef_stage),
    .coef_slot_i  (in_i.coef_slot),
    .coef_value_i (in_i.coef_value),
    .sample_out_o (out_o.sample_out)
  );

endmodule

// ===== src/bqeq_ctrl.sv =====
module bqeq_ctrl
  import bqeq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_command_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  `include "biquad_cascade_equalizer_core_assert.svh"

  state_e             state_q, state_d;
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    stage_d        = stage_q;
    step_d         = step_q;
    cmd_o          = '0;
    cmd_o.step     = step_q;
    cmd_o.stage    = stage_q;
    in_ready_o     = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_command_i == CMD_FILTER) begin
            cmd_o.load = 1'b1;
            stage_d    = '0;
            step_d     = '0;
            state_d    = ST_MAC;
          end else begin
            cmd_o.coef_wr = 1'b1;
          end
        end
      end
      ST_MAC: begin
        cmd_o.mac = 1'b1;
        if (step_q == STEP_W'(MAC_STEPS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      // last product still goes into the accumulator here
      ST_DRAIN: begin
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        if (stage_q == STAGE_W'(STAGE_COUNT - 1)) begin
          state_d = ST_DONE;
        end else begin
          stage_d = stage_q + 1'b1;
          step_d  = '0;
          state_d = ST_MAC;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  end

  assign out_valid_o = out_valid_q;

  `BQEQ_ASSERT_NEXT(a_filter_starts,
    in_valid_i && in_ready_o && in_command_i == CMD_FILTER,
    state_q == ST_MAC && stage_q == '0 && step_q == '0,
    "filter word did not start at the first stage")
  `BQEQ_ASSERT_NEXT(a_done_waits,
    state_q == ST_DONE && out_valid_o && !out_ready_i,
    state_q == ST_DONE,
    "result overwrote a word not yet taken")
  `BQEQ_ASSERT_ALWAYS(a_step_range,
    state_q != ST_MAC || step_q < STEP_W'(MAC_STEPS),
    "mac step out of range")
  `BQEQ_ASSERT_ALWAYS(a_valid_source,
    !$rose(out_valid_o) || $past(state_q) == ST_DONE,
    "output valid raised outside completion")

endmodule

// ===== src/bqeq_dp.sv =====
module bqeq_dp
  import bqeq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic [STAGE_FIELD_W-1:0]   coef_stage_i,
  input  logic [SLOT_W-1:0]          coef_slot_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o
);

  logic signed [COEF_W-1:0]   coef_q [STAGE_COUNT][NUM_SLOTS];
  logic [SAMPLE_W-1:0]        xh_q   [STAGE_COUNT][2];
  logic [HIST_W-1:0]          yh_q   [STAGE_COUNT][2];

  logic [SAMPLE_W-1:0]        cur_x_q;
  logic [SAMPLE_W-1:0]        out_q;

  step_info_t                 info;
  logic signed [COEF_W-1:0]   coef;
  logic [HIST_W-1:0]          yv;
  logic [MUL_B_W-1:0]         half;
  logic signed [MUL_B_W-1:0]  opb;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic                       mac_q, first_q, high_q, sub_q;

  logic signed [ACC_W-1:0]    term, shifted, base, acc_d, acc_q;
  logic [ACC_W-1:0]           bias, biased;
  logic [SCALED_W-1:0]        scaled_q;
  logic [HIST_W-1:0]          y48;
  logic                       wr_ok;

  localparam logic [ACC_W-1:0] FRAC_MASK = ACC_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

  // operand select and multiply
  always_comb begin
    info = step_info(cmd_i.step);
    coef = coef_q[cmd_i.stage][info.slot];
    yv   = (info.slot == SLOT_A1) ? yh_q[cmd_i.stage][0] : yh_q[cmd_i.stage][1];
    half = info.high ? MUL_B_W'(signed'(yv[HIST_W-1:HALF_W])) : MUL_B_W'(yv[HALF_W-1:0]);
    unique case (info.slot)
      SLOT_B0: opb = MUL_B_W'(signed'(cur_x_q));
      SLOT_B1: opb = MUL_B_W'(signed'(xh_q[cmd_i.stage][0]));
      SLOT_B2: opb = MUL_B_W'(signed'(xh_q[cmd_i.stage][1]));
      default: opb = signed'(half);
    endcase
    prod_d = PROD_W'(coef) * PROD_W'(opb);
  end

  // accumulate previous cycle's product; rounding bias, history clamp and write-range check
  always_comb begin
    term    = ACC_W'(prod_q);
    shifted = high_q ? (term <<< HALF_W) : term;
    base    = first_q ? '0 : acc_q;
    acc_d   = sub_q ? (base - shifted) : (base + shifted);
    bias    = acc_q[ACC_W-1] ? FRAC_MASK : '0;
    biased  = acc_q + bias;
    y48     = sat_hist(scaled_q);
    wr_ok   = (int'(coef_stage_i) < STAGE_COUNT) && (int'(coef_slot_i) < NUM_SLOTS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= 1'b0;
      for (int s = 0; s < STAGE_COUNT; s++) begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
          coef_q[s][k] <= (k == 0) ? COEF_W'(64'd1 << COEF_FRAC_BITS) : '0;
        end
        xh_q[s][0] <= '0;
        xh_q[s][1] <= '0;
        yh_q[s][0] <= '0;
        yh_q[s][1] <= '0;
      end
    end else begin
      mac_q <= cmd_i.mac;
      if (cmd_i.coef_wr && wr_ok) begin
        coef_q[STAGE_W'(coef_stage_i)][coef_slot_i] <= coef_value_i;
      end
      if (cmd_i.sat) begin
        xh_q[cmd_i.stage][1] <= xh_q[cmd_i.stage][0];
        xh_q[cmd_i.stage][0] <= cur_x_q;
        yh_q[cmd_i.stage][1] <= yh_q[cmd_i.stage][0];
        yh_q[cmd_i.stage][0] <= y48;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    first_q <= (cmd_i.step == '0);
    high_q  <= info.high;
    sub_q   <= info.sub;
    if (mac_q) acc_q <= acc_d;
    if (cmd_i.scale) scaled_q <= biased[ACC_W-1:COEF_FRAC_BITS];
    if (cmd_i.load) begin
      cur_x_q <= sample_in_i;
    end else if (cmd_i.sat) begin
      cur_x_q <= sat_sample(y48);
    end
    if (cmd_i.out_load) out_q <= cur_x_q;
  end

  assign sample_out_o = signed'(out_q);

endmodule

// ===== tb/tb_biquad_cascade_equalizer_core.sv =====
module tb_biquad_cascade_equalizer_core;
  import bqeq_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int WORD_TARGET  = 1000;

  localparam logic signed [SAMPLE_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [SAMPLE_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [COEF_W-1:0]   COEF_MAX = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0]   COEF_MIN = 32'sh8000_0000;
  localparam logic signed [COEF_W-1:0]   COEF_ONE = 32'sd1 <<< COEF_FRAC_BITS;
  localparam logic signed [95:0]         HIST_HI  = (96'sd1 <<< (HIST_W - 1)) - 96'sd1;
  localparam logic signed [95:0]         HIST_LO  = -(96'sd1 <<< (HIST_W - 1));

  logic clk_i;
  logic rst_ni;

  bqeq_in_if  in_if ();
  bqeq_out_if out_if ();

  biquad_cascade_equalizer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // filter state as the block should hold it
  logic signed [COEF_W-1:0]   coef_bank [STAGE_COUNT][NUM_SLOTS];
  logic signed [SAMPLE_W-1:0] x_past    [STAGE_COUNT][2];
  logic signed [HIST_W-1:0]   y_past    [STAGE_COUNT][2];
  logic signed [SAMPLE_W-1:0] expected_samples [$];

  int error_count;
  int words_sent;
  int idle_cycles;
  bit sender_steady;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic signed [SAMPLE_W-1:0] cascade_output(
    input logic signed [SAMPLE_W-1:0] in_sample);
    logic signed [95:0]         acc;
    logic [95:0]                mag;
    logic signed [95:0]         quot;
    logic signed [HIST_W-1:0]   y;
    longint                     wide_y;
    logic signed [SAMPLE_W-1:0] x;
    x = in_sample;
    for (int s = 0; s < STAGE_COUNT; s++) begin
      acc = coef_bank[s][SLOT_B0] * x
          + coef_bank[s][SLOT_B1] * x_past[s][0]
          + coef_bank[s][SLOT_B2] * x_past[s][1]
          - coef_bank[s][SLOT_A1] * y_past[s][0]
          - coef_bank[s][SLOT_A2] * y_past[s][1];
      // drop the fraction toward zero, then clamp to the history width
      mag  = acc[95] ? -acc : acc;
      quot = mag >> COEF_FRAC_BITS;
      if (acc[95]) quot = -quot;
      if (quot > HIST_HI) y = HIST_HI[HIST_W-1:0];
      else if (quot < HIST_LO) y = HIST_LO[HIST_W-1:0];
      else y = quot[HIST_W-1:0];
      x_past[s][1] = x_past[s][0];
      x_past[s][0] = x;
      y_past[s][1] = y_past[s][0];
      y_past[s][0] = y;
      wide_y = y;
      if (wide_y > WORD_MAX) x = WORD_MAX;
      else if (wide_y < WORD_MIN) x = WORD_MIN;
      else x = y[SAMPLE_W-1:0];
    end
    return x;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  // results are checked before new words are predicted at the same edge
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample_out %0d", out_if.sample_out));
      end else begin
        if (out_if.sample_out !== expected_samples[0])
          report_mismatch($sformatf("sample_out expected %0d got %0d",
                                    expected_samples[0], out_if.sample_out));
        void'(expected_samples.pop_front());
      end
    end
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (in_if.command == CMD_COEF) begin
        if (in_if.coef_stage < STAGE_COUNT && in_if.coef_slot < NUM_SLOTS)
          coef_bank[in_if.coef_stage][in_if.coef_slot] = in_if.coef_value;
      end else begin
        expected_samples.push_back(cascade_output(in_if.sample_in));
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_biquad_cascade_equalizer_core failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // back pressure on results: short and long stalls between bursts
  initial begin : result_sink
    int g;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk_i);
      g = pick_gap();
      if (g > 0) begin
        out_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(input cmd_e cmd, input logic signed [SAMPLE_W-1:0] in_sample,
                           input logic [STAGE_FIELD_W-1:0] stage,
                           input logic [SLOT_W-1:0] slot,
                           input logic signed [COEF_W-1:0] value);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.command    <= cmd;
    in_if.sample_in  <= in_sample;
    in_if.coef_stage <= stage;
    in_if.coef_slot  <= slot;
    in_if.coef_value <= value;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] in_sample);
    send_word(CMD_FILTER, in_sample, 3'($urandom), 3'($urandom), $urandom);
  endtask

  task automatic write_coef(input logic [STAGE_FIELD_W-1:0] stage,
                            input logic [SLOT_W-1:0] slot,
                            input logic signed [COEF_W-1:0] value);
    send_word(CMD_COEF, $urandom, stage, slot, value);
  endtask

  task automatic load_passthrough();
    for (int s = 0; s < STAGE_COUNT; s++)
      for (int k = 0; k < NUM_SLOTS; k++)
        write_coef(3'(s), 3'(k), (k == SLOT_B0) ? COEF_ONE : '0);
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef(input logic [SLOT_W-1:0] slot);
    int r;
    int lim;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return COEF_MAX;
        1:       return COEF_MIN;
        2:       return COEF_ONE;
        default: return '0;
      endcase
    end
    if (r < 18) return $urandom;
    // feedback kept moderate so most filters stay out of saturation
    if (slot == SLOT_A1) lim = (COEF_ONE * 3) / 2;
    else if (slot == SLOT_A2) lim = (COEF_ONE * 3) / 4;
    else lim = COEF_ONE;
    return $urandom_range(0, 2 * lim) - lim;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MAX;
        1:       return WORD_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 45) return $urandom;
    return $urandom_range(0, 131072) - 65536;
  endfunction

  task automatic test_reset_passthrough();
    send_sample('0);
    send_sample(WORD_MAX);
    send_sample(WORD_MIN);
    send_sample('1);
  endtask

  task automatic test_ignored_writes();
    write_coef(3'(STAGE_COUNT), SLOT_B0, '0);
    write_coef('1, SLOT_B0, '0);
    write_coef('0, 3'(NUM_SLOTS), COEF_MIN);
    write_coef('0, '1, COEF_MIN);
    send_sample(32'sd12345);
  endtask

  task automatic test_saturation();
    write_coef('0, SLOT_B0, COEF_MAX);
    send_sample(WORD_MAX);
    send_sample(WORD_MIN);
    write_coef('0, SLOT_B0, COEF_MIN);
    // strong positive feedback drives the history into its 48-bit clamp
    write_coef('0, SLOT_A1, COEF_MIN);
    repeat (5) send_sample(WORD_MAX);
  endtask

  task automatic test_slots();
    write_coef(3'(STAGE_COUNT - 1), SLOT_B1, COEF_ONE / 2);
    write_coef(3'(STAGE_COUNT - 1), SLOT_B2, -(COEF_ONE / 4));
    write_coef(3'(STAGE_COUNT - 1), SLOT_A2, COEF_ONE / 2);
    send_sample(32'sd1000);
    send_sample(-32'sd7);
  endtask

  task automatic test_random_streams();
    logic [SLOT_W-1:0] slot;
    load_passthrough();
    while (words_sent < WORD_TARGET) begin
      sender_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) load_passthrough();
      repeat ($urandom_range(1, 6)) begin
        slot = 3'($urandom_range(0, NUM_SLOTS - 1));
        write_coef(3'($urandom_range(0, STAGE_COUNT - 1)), slot, pick_coef(slot));
      end
      repeat ($urandom_range(4, 30)) begin
        if ($urandom_range(0, 9) == 0)
          send_word(cmd_e'($urandom_range(0, 1)), $urandom, 3'($urandom), 3'($urandom),
                    $urandom);
        else
          send_sample(pick_sample());
      end
    end
    sender_steady = 1'b0;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.command    <= CMD_FILTER;
    in_if.sample_in  <= '0;
    in_if.coef_stage <= '0;
    in_if.coef_slot  <= '0;
    in_if.coef_value <= '0;
    error_count   = 0;
    words_sent    = 0;
    idle_cycles   = 0;
    sender_steady = 1'b0;
    foreach (coef_bank[s, k]) coef_bank[s][k] = (k == SLOT_B0) ? COEF_ONE : '0;
    foreach (x_past[s, k]) x_past[s][k] = '0;
    foreach (y_past[s, k]) y_past[s][k] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_passthrough();
    test_ignored_writes();
    test_saturation();
    test_slots();
    test_random_streams();

    in_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_biquad_cascade_equalizer_core passed");
    end else begin
      $display("tb_biquad_cascade_equalizer_core failed");
    end
    $finish;
  end

endmodule
